[rtl/bmprle_pkg.sv]
`timescale 1ns / 1ps

package bmprle_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CFG_W   = 13;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = 2 * DIM_W;
    localparam int COL_W   = $clog2(MAX_DIM + 256);
    localparam int DEST_W  = 24;

    localparam logic [1:0] MODE_RLE8 = 2'd1;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } cfg_sel_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } strm_beat_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_index;
        logic [7:0]        pixel_value;
        logic [7:0]        fill_count;
        logic              end_of_image;
        logic              overrun;
        logic              mode_error;
    } run_beat_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [IDX_W-1:0] total;
        logic             mode_ok;
    } geom_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

[rtl/bmp_rle8_decoder.sv]
`timescale 1ns / 1ps

// channel   dir  handshake               beat
// strm      in   strm_valid/strm_ready   strm_data: data_byte, start_of_image
// run       out  run_valid/run_ready     run_data: dest_index, pixel_value, fill_count,
//                                        end_of_image, overrun, mode_error
// cfg       in   cfg_we                  cfg_idx, cfg_wdata
//
// one byte per cycle sustained unless a config write or a stalled run beat holds it;
// a byte is registered in the input register, then parsed into the result register
// a config write holds parsing while width times height is registered, then while
// the column within the row is rebuilt from the index
// rst_n is asynchronous: parser state clears, config returns to 1 x 1, mode 1
// a stalled run beat holds; one more byte waits in the input register

module bmp_rle8_decoder
    import bmprle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_idx,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             strm_valid,
    output logic             strm_ready,
    input  strm_beat_t       strm_data,
    output logic             run_valid,
    input  logic             run_ready,
    output run_beat_t        run_data
);

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [1:0]       mode_cfg_reg;
    geom_t            geom_reg, geom_next;
    logic             settle_reg;
    logic             hold_valid_reg;
    strm_beat_t       hold_reg;
    logic             run_valid_reg;
    run_beat_t        run_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             fire;
    logic             rc_busy;
    logic             res_valid;
    run_beat_t        res;

    assign fire       = hold_valid_reg && !settle_reg && !rc_busy
                        && (!run_valid_reg || run_ready);
    assign strm_ready = !hold_valid_reg || fire;
    assign run_valid  = run_valid_reg;
    assign run_data   = run_reg;

    always_comb
    begin
        eff_w             = eff_dim(width_cfg_reg);
        eff_h             = eff_dim(height_cfg_reg);
        geom_next.width   = eff_w;
        geom_next.total   = IDX_W'(eff_w) * IDX_W'(eff_h);
        geom_next.mode_ok = (mode_cfg_reg == MODE_RLE8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg    <= CFG_W'(1);
            height_cfg_reg   <= CFG_W'(1);
            mode_cfg_reg     <= MODE_RLE8;
            geom_reg.width   <= DIM_W'(1);
            geom_reg.total   <= IDX_W'(1);
            geom_reg.mode_ok <= 1'b1;
            settle_reg       <= 1'b0;
            hold_valid_reg   <= 1'b0;
            run_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_cfg_reg <= cfg_wdata;
                    CFG_MODE:   mode_cfg_reg   <= cfg_wdata[1:0];
                    default:    ;
                endcase
            end
            geom_reg   <= geom_next;
            settle_reg <= cfg_we;

            if (strm_ready)
            begin
                hold_valid_reg <= strm_valid;
            end

            if (fire && res_valid)
            begin
                run_valid_reg <= 1'b1;
            end
            else if (run_ready)
            begin
                run_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (strm_valid && strm_ready)
        begin
            hold_reg <= strm_data;
        end
        if (fire && res_valid)
        begin
            run_reg <= res;
        end
    end

    bmprle_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .recol     (settle_reg),
        .busy      (rc_busy),
        .beat      (hold_reg),
        .geom      (geom_reg),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

[rtl/bmprle_parser.sv]
`timescale 1ns / 1ps

module bmprle_parser
    import bmprle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       recol,
    output logic       busy,
    input  strm_beat_t beat,
    input  geom_t      geom,
    output logic       res_valid,
    output run_beat_t  res
);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_ESC,
        PH_DX,
        PH_DY,
        PH_LIT,
        PH_PAD
    } phase_t;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    localparam int RC_W = $clog2(IDX_W + 1);

    phase_t           phase_reg, ph_b, ph_n;
    logic [7:0]       count_reg, count_b, count_n;
    logic [7:0]       lit_reg, lit_b, lit_n, lit_dec;
    logic [7:0]       dx_reg, dx_b, dx_n;
    logic [IDX_W-1:0] idx_reg, idx_b, idx_n;
    logic             parity_reg, parity_b, parity_n;
    logic             fin_reg, fin_b, fin_n;
    logic             rep_reg, rep_b, rep_n;
    logic [DIM_W-1:0] col_reg, col_b, col_n, col_inc, col_lit, col_red;
    logic [COL_W-1:0] raw_reg, raw_new;
    logic             pend_reg;
    logic             col_we, big_add;

    logic [IDX_W-1:0] rc_num_reg;
    logic [DIM_W-1:0] rc_rem_reg, rc_rem_next;
    logic [RC_W-1:0]  rc_cnt_reg;
    logic [DIM_W:0]   rc_shift;

    logic [7:0]       byte_in, wr_cnt, clip, col_amt;
    logic [IDX_W-1:0] avail, adv_amt, adv_idx, eol_tgt, eol_idx;
    logic [IDX_W:0]   adv_sum;
    logic [DIM_W+7:0] dy_prod;
    logic             ovr;
    logic [COL_W+7:0] red_rem, red_div;

    // column reduction of a pending advance, applied in the cycle after it
    always_comb
    begin
        red_rem = (COL_W + 8)'(raw_reg);
        red_div = '0;
        for (int k = 7; k >= 0; k--)
        begin
            red_div = (COL_W + 8)'(geom.width) << k;
            if (red_rem >= red_div)
            begin
                red_rem = red_rem - red_div;
            end
        end
        col_red = DIM_W'(red_rem);
    end

    // column rebuild after a config write, one index bit per cycle
    always_comb
    begin
        rc_shift    = {rc_rem_reg, rc_num_reg[IDX_W-1]};
        rc_rem_next = (rc_shift >= {1'b0, geom.width})
                    ? DIM_W'(rc_shift - {1'b0, geom.width})
                    : rc_shift[DIM_W-1:0];
        busy        = (rc_cnt_reg != '0);
    end

    always_comb
    begin
        byte_in  = beat.data_byte;
        ph_b     = beat.start_of_image ? PH_COUNT : phase_reg;
        count_b  = beat.start_of_image ? 8'd0 : count_reg;
        lit_b    = beat.start_of_image ? 8'd0 : lit_reg;
        dx_b     = beat.start_of_image ? 8'd0 : dx_reg;
        idx_b    = beat.start_of_image ? '0 : idx_reg;
        parity_b = beat.start_of_image ? 1'b0 : parity_reg;
        fin_b    = beat.start_of_image ? 1'b0 : fin_reg;
        rep_b    = beat.start_of_image ? 1'b0 : rep_reg;
        col_b    = beat.start_of_image ? '0 : col_reg;

        // shared write and advance arithmetic
        wr_cnt  = (ph_b == PH_LIT) ? 8'd1 : count_b;
        avail   = (idx_b < geom.total) ? geom.total - idx_b : '0;
        ovr     = (IDX_W'(wr_cnt) > avail);
        clip    = ovr ? avail[7:0] : wr_cnt;
        dy_prod = byte_in * geom.width;
        adv_amt = (ph_b == PH_DY) ? (IDX_W'(dx_b) + IDX_W'(dy_prod)) : IDX_W'(wr_cnt);
        adv_sum = {1'b0, idx_b} + {1'b0, adv_amt};
        adv_idx = (adv_sum > {1'b0, geom.total}) ? geom.total : adv_sum[IDX_W-1:0];

        // end of line
        eol_tgt = (col_b == '0 && rep_b) ? idx_b
                                         : idx_b - IDX_W'(col_b) + IDX_W'(geom.width);
        if (idx_b < geom.total)
        begin
            eol_idx = (eol_tgt > geom.total) ? geom.total : eol_tgt;
        end
        else
        begin
            eol_idx = idx_b;
        end

        col_inc = col_b + DIM_W'(1);
        col_lit = (col_inc == geom.width) ? '0 : col_inc;
        col_amt = (ph_b == PH_DY) ? dx_b : count_b;
        raw_new = COL_W'(col_b) + COL_W'(col_amt);
        lit_dec = lit_b - 8'd1;

        ph_n     = ph_b;
        count_n  = count_b;
        lit_n    = lit_b;
        dx_n     = dx_b;
        idx_n    = idx_b;
        parity_n = parity_b;
        fin_n    = fin_b;
        rep_n    = rep_b;
        col_n    = col_b;
        col_we   = beat.start_of_image;
        big_add  = 1'b0;

        res_valid      = 1'b0;
        res            = '0;
        res.dest_index = DEST_W'(idx_b);

        if (!geom.mode_ok)
        begin
            res_valid      = 1'b1;
            res.mode_error = 1'b1;
        end
        else if (!fin_b)
        begin
            parity_n = ~parity_b;
            unique case (ph_b)
                PH_COUNT:
                begin
                    if (byte_in == 8'd0)
                    begin
                        ph_n = PH_ESC;
                    end
                    else
                    begin
                        count_n = byte_in;
                        ph_n    = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    res_valid       = 1'b1;
                    res.pixel_value = byte_in;
                    res.fill_count  = clip;
                    res.overrun     = ovr;
                    idx_n           = adv_idx;
                    rep_n           = 1'b1;
                    count_n         = 8'd0;
                    big_add         = 1'b1;
                    ph_n            = PH_COUNT;
                end
                PH_ESC:
                begin
                    priority if (byte_in == ESC_EOL)
                    begin
                        idx_n  = eol_idx;
                        rep_n  = 1'b0;
                        col_n  = '0;
                        col_we = 1'b1;
                        ph_n   = PH_COUNT;
                    end
                    else if (byte_in == ESC_EOB)
                    begin
                        res_valid        = 1'b1;
                        res.end_of_image = 1'b1;
                        fin_n            = 1'b1;
                        ph_n             = PH_COUNT;
                    end
                    else if (byte_in == ESC_DELTA)
                    begin
                        ph_n = PH_DX;
                    end
                    else
                    begin
                        lit_n = byte_in;
                        ph_n  = PH_LIT;
                    end
                end
                PH_DX:
                begin
                    dx_n = byte_in;
                    ph_n = PH_DY;
                end
                PH_DY:
                begin
                    idx_n   = adv_idx;
                    rep_n   = 1'b0;
                    dx_n    = 8'd0;
                    big_add = 1'b1;
                    ph_n    = PH_COUNT;
                end
                PH_LIT:
                begin
                    res_valid       = 1'b1;
                    res.pixel_value = byte_in;
                    res.fill_count  = clip;
                    res.overrun     = ovr;
                    idx_n           = adv_idx;
                    rep_n           = 1'b1;
                    col_n           = col_lit;
                    col_we          = 1'b1;
                    lit_n           = lit_dec;
                    if (lit_dec == 8'd0)
                    begin
                        ph_n = parity_n ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD:
                begin
                    ph_n = PH_COUNT;
                end
                default:
                begin
                    ph_n = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COUNT;
            count_reg  <= 8'd0;
            lit_reg    <= 8'd0;
            dx_reg     <= 8'd0;
            idx_reg    <= '0;
            parity_reg <= 1'b0;
            fin_reg    <= 1'b0;
            rep_reg    <= 1'b0;
            col_reg    <= '0;
            pend_reg   <= 1'b0;
            rc_num_reg <= '0;
            rc_rem_reg <= '0;
            rc_cnt_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg  <= ph_n;
                count_reg  <= count_n;
                lit_reg    <= lit_n;
                dx_reg     <= dx_n;
                idx_reg    <= idx_n;
                parity_reg <= parity_n;
                fin_reg    <= fin_n;
                rep_reg    <= rep_n;
            end
            if (fire && col_we)
            begin
                col_reg <= col_n;
            end
            else if (pend_reg)
            begin
                col_reg <= col_red;
            end
            else if (rc_cnt_reg == RC_W'(1))
            begin
                col_reg <= rc_rem_next;
            end
            pend_reg <= fire && big_add;

            if (recol)
            begin
                rc_num_reg <= idx_reg;
                rc_rem_reg <= '0;
                rc_cnt_reg <= RC_W'(IDX_W);
            end
            else if (busy)
            begin
                rc_num_reg <= rc_num_reg << 1;
                rc_rem_reg <= rc_rem_next;
                rc_cnt_reg <= rc_cnt_reg - RC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && big_add)
        begin
            raw_reg <= raw_new;
        end
    end

endmodule
